@@ hdl/pics_pkg.sv @@
package pics_pkg;

   localparam int unsigned DataWidth   = 8;
   localparam int unsigned WordWidth   = 16;
   localparam int unsigned AccWidth    = 17;
   localparam int unsigned CountWidth  = 32;
   localparam int unsigned CsrWidth    = 32;
   localparam int unsigned CsrIdxWidth = 4;

   // register indexes of the configuration port
   localparam logic [CsrIdxWidth-1:0] CSR_SKIP_OFFSET  = 4'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_EXPECTED_SUM = 4'd1;

   // offset of the second skipped word and length of the skipped field
   localparam logic [CountWidth-1:0] SkipSecondWord = 32'd2;
   localparam logic [CountWidth:0]   SkipFieldLen   = 33'd4;

   // finished file handed from the accumulator to the result stage
   typedef struct packed {
      logic [AccWidth-1:0]   acc;
      logic [CountWidth-1:0] len;
   } fin_type;

   // add a 16-bit word into the 17-bit accumulator and fold the carry back
   function automatic logic [AccWidth-1:0] fold_add(input logic [AccWidth-1:0]  acc,
                                                    input logic [WordWidth-1:0] val);
      logic [AccWidth:0] s;
      logic [AccWidth:0] f;
      s = {1'b0, acc} + {2'b00, val};
      f = {2'b00, s[WordWidth-1:0]} + {{(AccWidth-1){1'b0}}, s[AccWidth:WordWidth]};
      return f[AccWidth-1:0];
   endfunction

endpackage

@@ hdl/pics_accum.sv @@
module pics_accum (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take,
   input  logic [pics_pkg::DataWidth-1:0]  data_byte,
   input  logic                            last_byte,
   input  logic [pics_pkg::CountWidth-1:0] skip_offset,
   input  logic                            fin_ready,
   output logic                            fin_valid,
   output pics_pkg::fin_type               fin
);
   import pics_pkg::*;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [DataWidth-1:0]  held_ff, held_in;
   logic [AccWidth-1:0]   acc_ff, acc_in;
   logic                  fin_valid_ff, fin_valid_in;
   fin_type               fin_ff, fin_in;

   logic                  odd_pos;
   logic [CountWidth-1:0] word_off;
   logic [CountWidth-1:0] pos_next;
   logic                  skip_hit;
   logic                  add_en;
   logic [WordWidth-1:0]  add_val;
   logic [AccWidth-1:0]   acc_new;

   // pair bytes, skip the stored checksum field, add the trailing odd byte
   always_comb begin
      odd_pos  = count_ff[0];
      word_off = count_ff - {{(CountWidth-1){1'b0}}, 1'b1};
      pos_next = count_ff + {{(CountWidth-1){1'b0}}, 1'b1};
      skip_hit = (word_off == skip_offset) || (word_off == skip_offset + SkipSecondWord);
      add_en   = odd_pos ? !skip_hit : last_byte;
      add_val  = odd_pos ? {data_byte, held_ff} : {{(WordWidth-DataWidth){1'b0}}, data_byte};
      acc_new  = add_en ? fold_add(acc_ff, add_val) : acc_ff;
   end

   // advance the stream state; clear it after the last word of a file
   always_comb begin
      count_in     = count_ff;
      held_in      = held_ff;
      acc_in       = acc_ff;
      fin_in       = fin_ff;
      fin_valid_in = fin_valid_ff && !fin_ready;
      if (take) begin
         if (last_byte) begin
            count_in     = '0;
            held_in      = '0;
            acc_in       = '0;
            fin_in.acc   = acc_new;
            fin_in.len   = pos_next;
            fin_valid_in = 1'b1;
         end else begin
            count_in = pos_next;
            held_in  = odd_pos ? held_ff : data_byte;
            acc_in   = acc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         held_ff      <= '0;
         acc_ff       <= '0;
         fin_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         held_ff      <= held_in;
         acc_ff       <= acc_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   // hold the finished file without reset
   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule

@@ hdl/pics_finish.sv @@
module pics_finish (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fin_valid,
   input  pics_pkg::fin_type               fin,
   output logic                            fin_ready,
   input  logic [pics_pkg::CsrWidth-1:0]   skip_offset,
   input  logic [pics_pkg::CsrWidth-1:0]   expected_sum,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pics_pkg::CountWidth-1:0] rsp_computed_sum,
   output logic                            rsp_sum_mismatch,
   output logic                            rsp_compare_valid
);
   import pics_pkg::*;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CountWidth-1:0] sum_ff, sum_in;
   logic                  mismatch_ff, mismatch_in;
   logic                  cmp_valid_ff, cmp_valid_in;

   logic [AccWidth-1:0]   folded;
   logic                  load;

   assign fin_ready = !rsp_valid_ff || !rsp_stall;
   assign load      = fin_valid && fin_ready;

   // final fold, add the length and compare with the stored checksum
   always_comb begin
      folded       = {1'b0, fin.acc[WordWidth-1:0]}
                   + {{(AccWidth-1){1'b0}}, fin.acc[AccWidth-1]};
      sum_in       = fin.len + {{(CountWidth-AccWidth){1'b0}}, folded};
      cmp_valid_in = (expected_sum != '0)
                   && (({1'b0, skip_offset} + SkipFieldLen) <= {1'b0, fin.len});
      mismatch_in  = cmp_valid_in && (sum_in != expected_sum);
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the result word only when the output register is free
   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff       <= sum_in;
         mismatch_ff  <= mismatch_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_computed_sum  = sum_ff;
   assign rsp_sum_mismatch  = mismatch_ff;
   assign rsp_compare_valid = cmp_valid_ff;

endmodule

@@ hdl/pe_image_checksum_stream_core.sv @@
// Streaming image checksum: 16-bit fold-add over little-endian byte pairs plus the length.
//
// Input channel req_*: one file byte per word, req_last_byte marks the final byte.
// A word is taken when req_valid is high and req_stall is low. Bytes of one file
// can follow each other in every cycle; a new file may start right after the last.
// Result channel rsp_*: one word per file, carrying the checksum, the compare flag
// and the mismatch flag. It is taken when rsp_valid is high and rsp_stall is low.
// A file's result is registered in the stage ahead, then in the output register, before it is offered.
// Throughput: one byte per cycle while req_stall is low, set by the single fold-add on the accumulator.
// Configuration csr_*: index 0 is the byte offset of the stored checksum field,
// index 1 the expected checksum (zero turns the compare off). Write only while idle.
// Reset clears the stream state, the pipeline valid flags and both registers.
// While the receiver stalls, one finished file waits in the output register and one
// in the stage ahead; bytes keep flowing until both are full. req_stall then rises
// and holds every byte until the output register is freed.
module pe_image_checksum_stream_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [pics_pkg::DataWidth-1:0]   req_data_byte,
   input  logic                             req_last_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [pics_pkg::CountWidth-1:0]  rsp_computed_sum,
   output logic                             rsp_sum_mismatch,
   output logic                             rsp_compare_valid,
   input  logic                             csr_write_enable,
   input  logic [pics_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [pics_pkg::CsrWidth-1:0]    csr_write_data
);
   import pics_pkg::*;

   logic [CsrWidth-1:0] skip_ff, skip_in;
   logic [CsrWidth-1:0] expect_ff, expect_in;

   logic    take;
   logic    fin_valid;
   logic    fin_ready;
   fin_type fin;

   // decode configuration writes; ignore unknown indexes
   always_comb begin
      skip_in   = skip_ff;
      expect_in = expect_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SKIP_OFFSET:  skip_in   = csr_write_data;
            CSR_EXPECTED_SUM: expect_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff   <= '0;
         expect_ff <= '0;
      end else begin
         skip_ff   <= skip_in;
         expect_ff <= expect_in;
      end
   end

   // stall only when a finished file cannot move on
   assign req_stall = fin_valid && !fin_ready;
   assign take      = req_valid && !req_stall;

   pics_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .skip_offset (skip_ff),
      .fin_ready   (fin_ready),
      .fin_valid   (fin_valid),
      .fin         (fin)
   );

   pics_finish u_finish (
      .clock             (clock),
      .reset             (reset),
      .fin_valid         (fin_valid),
      .fin               (fin),
      .fin_ready         (fin_ready),
      .skip_offset       (skip_ff),
      .expected_sum      (expect_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_computed_sum  (rsp_computed_sum),
      .rsp_sum_mismatch  (rsp_sum_mismatch),
      .rsp_compare_valid (rsp_compare_valid)
   );

   // a taken last byte always leaves a finished file in the stage ahead
   a_last_to_fin: assert property (@(posedge clock) disable iff (reset)
      take && req_last_byte |=> fin_valid)
      else $error("last byte taken but no finished file");

   // a mismatch is only reported when the compare is valid
   a_mismatch_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sum_mismatch |-> rsp_compare_valid)
      else $error("mismatch without a valid compare");

   // a valid compare needs a nonzero expected checksum
   a_valid_needs_expect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_valid |-> expect_ff != '0)
      else $error("compare valid with expected checksum zero");

   // a pending result that is stalled stays offered
   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && fin_valid == $past(fin_valid || take && req_last_byte))
      else $error("stalled result dropped");

endmodule
